FILE: sv/assert_macros.svh
// assertion helpers for the rtl, included by trial_division_prime_test
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define TDP_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define TDP_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

FILE: sv/tdp_pkg.sv
package tdp_pkg;

    // status from the remainder unit to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } tdp_rem_status_t;

    localparam int unsigned FIRST_DIVISOR = 2;

endpackage

FILE: sv/tdp_cand_if.sv
interface tdp_cand_if #(
    parameter int unsigned VALUE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink (input valid, input candidate, output ready);
endinterface

FILE: sv/tdp_result_if.sv
interface tdp_result_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink (input valid, input is_prime, output ready);
endinterface

FILE: sv/tdp_rem_unit.sv
module tdp_rem_unit
    import tdp_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output tdp_rem_status_t       status
);

    localparam int unsigned CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] num_reg, num_next;
    logic [VALUE_BITS-1:0] div_reg, div_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, num_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_BITS - 1);
            num_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[VALUE_BITS-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[VALUE_BITS-1:0];
            end
            else
            begin
                rem_next = trial[VALUE_BITS-1:0];
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule

FILE: sv/trial_division_prime_test.sv
// candidates below 4 meet the square-root bound at once and try no divisor; others
//   run one bit-serial remainder pass per divisor tried
// throughput: one candidate at a time; worst case for a 16-bit prime is about
//   254 divisors, each a full pass of the bit-serial remainder unit
// reset: rst_n asynchronous, active low; clears the sequencer and the output valid
`include "assert_macros.svh"

module trial_division_prime_test
    import tdp_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    tdp_cand_if.sink   cand,
    tdp_result_if.source result
);

    // divisor squared stays below 2^(VALUE_BITS+1), two guard bits are enough
    localparam int unsigned SQ_W = VALUE_BITS + 2;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] n_reg, n_next;       // candidate under test
    logic [VALUE_BITS-1:0] d_reg, d_next;       // current trial divisor
    logic [SQ_W-1:0]       sq_reg, sq_next;     // d_reg squared, kept by adding 2d+1
    logic                  prime_reg, prime_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_prime_reg, out_prime_next;
    logic                  rem_start;
    logic                  slot_free;
    tdp_rem_status_t       rem_status;

    tdp_rem_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .status   (rem_status)
    );

    // new candidates only while the sequencer is free; output register parts the sides
    assign cand.ready = (state_reg == ST_IDLE);
    assign slot_free  = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        prime_next     = prime_reg;
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        rem_start      = 1'b0;

        // result transfer frees the output register
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cand.valid)
                begin
                    n_next     = cand.candidate;
                    d_next     = VALUE_BITS'(FIRST_DIVISOR);
                    sq_next    = SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (n_reg < VALUE_BITS'(FIRST_DIVISOR))
                begin
                    // zero and one are not prime
                    prime_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (sq_reg > {{(SQ_W-VALUE_BITS){1'b0}}, n_reg})
                begin
                    // no divisor up to the square root
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_status.done)
                begin
                    if (rem_status.rem_zero)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_next    = sq_reg + {1'b0, d_reg, 1'b1};
                        d_next     = d_reg + 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = prime_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        prime_reg     <= prime_next;
        out_prime_reg <= out_prime_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.is_prime = out_prime_reg;

    // remainder results only arrive while the sequencer waits for them
    `TDP_ASSERT_IMP(a_done_in_div, clk, rst_n, rem_status.done, state_reg == ST_DIV, "remainder done outside divide state")

    // an accepted candidate starts the walk at the first divisor
    `TDP_ASSERT_NEXT(a_accept_init, clk, rst_n, cand.valid && cand.ready, (state_reg == ST_CHECK) && (d_reg == VALUE_BITS'(FIRST_DIVISOR)), "walk not started at first divisor")

    // a pending result is never overwritten before its transfer
    `TDP_ASSERT_IMP(a_no_overwrite, clk, rst_n, (state_reg == ST_FINISH) && out_valid_reg && !result.ready, state_next == ST_FINISH, "finished result dropped")

endmodule
